// ===== rtl/bcdec_pkg.sv =====
// Shared types and constants of the BC1/BC2/BC3 block decoder.
package bcdec_pkg;

    localparam int MAX_DIM_DEFAULT     = 4096;
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    localparam int DIM_W     = 13;
    localparam int FMT_W     = 2;
    localparam int CFG_IDX_W = 2;
    localparam int IN_DATA_W  = 128;
    localparam int OUT_DATA_W = 56;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FORMAT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

    // Format codes; any other code decodes as BC3.
    localparam logic [FMT_W-1:0] FMT_BC1 = 2'd0;
    localparam logic [FMT_W-1:0] FMT_BC2 = 2'd1;

    typedef enum logic [1:0] {
        KIND_BC1_OPAQUE,
        KIND_BC1_PUNCH,
        KIND_BC2,
        KIND_BC3
    } kind_t;

    typedef struct packed {
        logic [FMT_W-1:0] block_format;
        logic [DIM_W-1:0] image_width;
        logic [DIM_W-1:0] image_height;
    } cfg_t;

    typedef struct packed {
        logic [63:0] alpha_word;
        logic [15:0] endpoint_a;
        logic [15:0] endpoint_b;
        logic [31:0] color_selectors;
        kind_t       kind;
        logic [11:0] base_x;
        logic [11:0] base_y;
        logic [1:0]  cols_m1;
        logic [1:0]  rows_m1;
        logic        last_block;
    } block_entry_t;

endpackage

// ===== rtl/bcdec_front.sv =====
// Front end: accepts compressed blocks, tracks block position and classifies each block.
module bcdec_front #(
    parameter int MAX_DIM = bcdec_pkg::MAX_DIM_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  bcdec_pkg::cfg_t                cfg,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [bcdec_pkg::IN_DATA_W-1:0] s_tdata,
    input  logic                           queue_full,
    output logic                           push,
    output bcdec_pkg::block_entry_t        entry
);

    localparam int DW  = $clog2(MAX_DIM + 1);
    localparam int EW  = ((DW > bcdec_pkg::DIM_W) ? DW : bcdec_pkg::DIM_W) + 1;
    localparam int BLK = (MAX_DIM + 3) / 4;
    localparam int BCW = $clog2(BLK + 1);
    localparam int PXW = ((BCW + 2) > 12) ? (BCW + 2) : 12;

    function automatic logic [DW-1:0] clamp_dim(input logic [bcdec_pkg::DIM_W-1:0] v);
        logic [EW-1:0] ext;
        ext = EW'(v);
        if (ext == '0) begin
            return DW'(1);
        end else if (ext > EW'(MAX_DIM)) begin
            return DW'(MAX_DIM);
        end else begin
            return DW'(ext);
        end
    endfunction

    logic [BCW-1:0] col_reg, col_next;
    logic [BCW-1:0] row_reg, row_next;
    logic [DW-1:0]  w_c, h_c;
    logic [BCW-1:0] bw, bh;
    logic [BCW-1:0] col_eff, row_eff;
    logic           last_block;
    logic [EW-1:0]  rem_x, rem_y;
    logic [PXW-1:0] bx_full, by_full;

    assign w_c = clamp_dim(cfg.image_width);
    assign h_c = clamp_dim(cfg.image_height);
    assign bw  = BCW'((EW'(w_c) + EW'(3)) >> 2);
    assign bh  = BCW'((EW'(h_c) + EW'(3)) >> 2);

    // A position left outside the grid by a size change restarts at the first block.
    always_comb begin
        if (col_reg >= bw || row_reg >= bh) begin
            col_eff = '0;
            row_eff = '0;
        end else begin
            col_eff = col_reg;
            row_eff = row_reg;
        end
    end

    assign last_block = (col_eff == bw - BCW'(1)) && (row_eff == bh - BCW'(1));
    assign rem_x      = EW'(w_c) - (EW'(col_eff) << 2);
    assign rem_y      = EW'(h_c) - (EW'(row_eff) << 2);
    assign bx_full    = PXW'(col_eff) << 2;
    assign by_full    = PXW'(row_eff) << 2;

    assign s_tready = ~queue_full;
    assign push     = s_tvalid & ~queue_full;

    always_comb begin
        entry.alpha_word      = s_tdata[63:0];
        entry.endpoint_a      = s_tdata[79:64];
        entry.endpoint_b      = s_tdata[95:80];
        entry.color_selectors = s_tdata[127:96];
        entry.base_x          = bx_full[11:0];
        entry.base_y          = by_full[11:0];
        entry.cols_m1         = (rem_x >= EW'(4)) ? 2'd3 : 2'(rem_x - EW'(1));
        entry.rows_m1         = (rem_y >= EW'(4)) ? 2'd3 : 2'(rem_y - EW'(1));
        entry.last_block      = last_block;
        case (cfg.block_format)
            bcdec_pkg::FMT_BC1: begin
                entry.kind = (s_tdata[79:64] <= s_tdata[95:80]) ?
                             bcdec_pkg::KIND_BC1_PUNCH : bcdec_pkg::KIND_BC1_OPAQUE;
            end
            bcdec_pkg::FMT_BC2: begin
                entry.kind = bcdec_pkg::KIND_BC2;
            end
            default: begin
                entry.kind = bcdec_pkg::KIND_BC3;
            end
        endcase
    end

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (push) begin
            if (last_block) begin
                col_next = '0;
                row_next = '0;
            end else if (col_eff + BCW'(1) >= bw) begin
                col_next = '0;
                row_next = row_eff + BCW'(1);
            end else begin
                col_next = col_eff + BCW'(1);
                row_next = row_eff;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

// ===== rtl/bcdec_queue.sv =====
// Short block queue between the front end and the texel back end.
module bcdec_queue #(
    parameter int DEPTH = bcdec_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  bcdec_pkg::block_entry_t push_entry,
    output logic                    full,
    input  logic                    pop,
    output logic                    head_valid,
    output bcdec_pkg::block_entry_t head_entry
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    bcdec_pkg::block_entry_t entries_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = entries_reg[rd_ptr_reg];
    assign do_push    = push & ~full;
    assign do_pop     = pop & head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== rtl/bcdec_back.sv =====
// Back end: walks the head block, decoding one texel per cycle while not stalled.
module bcdec_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            head_valid,
    input  bcdec_pkg::block_entry_t         head_entry,
    output logic                            pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bcdec_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                            m_tlast,
    output logic                            m_tuser
);

    typedef enum logic [2:0] {
        OP_PASS,
        OP_HALF,
        OP_DIV3,
        OP_DIV5,
        OP_DIV7
    } op_t;

    // Reciprocals for exact floor division over the numerator ranges that occur.
    localparam logic [21:0] RECIP3 = 22'd683;
    localparam logic [24:0] RECIP5 = 25'd3277;
    localparam logic [24:0] RECIP7 = 25'd2341;

    function automatic logic [7:0] apply_op(input op_t op, input logic [10:0] num);
        logic [21:0] p3;
        logic [24:0] p5;
        logic [24:0] p7;
        p3 = 22'(num) * RECIP3;
        p5 = 25'(num) * RECIP5;
        p7 = 25'(num) * RECIP7;
        case (op)
            OP_PASS: return num[7:0];
            OP_HALF: return num[8:1];
            OP_DIV3: return p3[18:11];
            OP_DIV5: return p5[21:14];
            OP_DIV7: return p7[21:14];
            default: return num[7:0];
        endcase
    endfunction

    logic        en, take, last_texel;
    logic [1:0]  x_reg, x_next;
    logic [1:0]  y_reg, y_next;
    logic [3:0]  texel;
    logic [1:0]  idx;
    logic [3:0]  nibble;
    logic [5:0]  code_base;
    logic [2:0]  code;
    logic [7:0]  a0, a1;
    logic [10:0] wa, wb;
    logic        punch;
    logic [7:0]  e0 [3];
    logic [7:0]  e1 [3];

    logic [10:0] cnum_next [3];
    op_t         cop_next  [3];
    logic [10:0] anum_next;
    op_t         aop_next;

    logic        a_valid_reg;
    logic [11:0] a_px_reg, a_py_reg;
    logic        a_lob_reg, a_loi_reg;
    logic [10:0] a_cnum_reg [3];
    op_t         a_cop_reg  [3];
    logic [10:0] a_anum_reg;
    op_t         a_aop_reg;

    logic        m_valid_reg;
    logic [bcdec_pkg::OUT_DATA_W-1:0] m_data_reg;
    logic        m_last_reg, m_user_reg;

    // The whole back pipeline moves whenever the output register can take a beat.
    assign en         = ~m_valid_reg | m_tready;
    assign take       = en & head_valid;
    assign last_texel = (x_reg == head_entry.cols_m1) && (y_reg == head_entry.rows_m1);
    assign pop        = take & last_texel;

    assign texel     = {y_reg, x_reg};
    assign idx       = head_entry.color_selectors[{texel, 1'b0} +: 2];
    assign nibble    = head_entry.alpha_word[{texel, 2'b00} +: 4];
    assign code_base = 6'd16 + {1'b0, texel, 1'b0} + {2'b00, texel};
    assign code      = head_entry.alpha_word[code_base +: 3];
    assign a0        = head_entry.alpha_word[7:0];
    assign a1        = head_entry.alpha_word[15:8];
    assign punch     = (head_entry.kind == bcdec_pkg::KIND_BC1_PUNCH);

    always_comb begin
        e0[0] = {head_entry.endpoint_a[15:11], 3'b000};
        e0[1] = {head_entry.endpoint_a[10:5], 2'b00};
        e0[2] = {head_entry.endpoint_a[4:0], 3'b000};
        e1[0] = {head_entry.endpoint_b[15:11], 3'b000};
        e1[1] = {head_entry.endpoint_b[10:5], 2'b00};
        e1[2] = {head_entry.endpoint_b[4:0], 3'b000};
        for (int c = 0; c < 3; c++) begin
            case (idx)
                2'd0: begin
                    cnum_next[c] = 11'(e0[c]);
                    cop_next[c]  = OP_PASS;
                end
                2'd1: begin
                    cnum_next[c] = 11'(e1[c]);
                    cop_next[c]  = OP_PASS;
                end
                2'd2: begin
                    if (punch) begin
                        cnum_next[c] = 11'(e0[c]) + 11'(e1[c]);
                        cop_next[c]  = OP_HALF;
                    end else begin
                        cnum_next[c] = (11'(e0[c]) << 1) + 11'(e1[c]) + 11'd1;
                        cop_next[c]  = OP_DIV3;
                    end
                end
                default: begin
                    if (punch) begin
                        cnum_next[c] = '0;
                        cop_next[c]  = OP_PASS;
                    end else begin
                        cnum_next[c] = 11'(e0[c]) + (11'(e1[c]) << 1) + 11'd1;
                        cop_next[c]  = OP_DIV3;
                    end
                end
            endcase
        end
    end

    always_comb begin
        wa        = '0;
        wb        = 11'(code) - 11'd1;
        anum_next = 11'd255;
        aop_next  = OP_PASS;
        case (head_entry.kind)
            bcdec_pkg::KIND_BC1_OPAQUE: begin
                anum_next = 11'd255;
            end
            bcdec_pkg::KIND_BC1_PUNCH: begin
                anum_next = (idx == 2'd3) ? 11'd0 : 11'd255;
            end
            bcdec_pkg::KIND_BC2: begin
                // A nibble times 17 is the nibble repeated in both halves.
                anum_next = {3'b000, nibble, nibble};
            end
            default: begin
                if (code == 3'd0) begin
                    anum_next = 11'(a0);
                end else if (code == 3'd1) begin
                    anum_next = 11'(a1);
                end else if (a0 > a1) begin
                    wa        = 11'd8 - 11'(code);
                    anum_next = wa * 11'(a0) + wb * 11'(a1) + 11'd3;
                    aop_next  = OP_DIV7;
                end else if (code <= 3'd5) begin
                    wa        = 11'd6 - 11'(code);
                    anum_next = wa * 11'(a0) + wb * 11'(a1) + 11'd2;
                    aop_next  = OP_DIV5;
                end else if (code == 3'd6) begin
                    anum_next = 11'd0;
                end else begin
                    anum_next = 11'd255;
                end
            end
        endcase
    end

    always_comb begin
        x_next = x_reg;
        y_next = y_reg;
        if (take) begin
            if (last_texel) begin
                x_next = '0;
                y_next = '0;
            end else if (x_reg == head_entry.cols_m1) begin
                x_next = '0;
                y_next = y_reg + 2'd1;
            end else begin
                x_next = x_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_reg       <= '0;
            y_reg       <= '0;
            a_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            x_reg <= x_next;
            y_reg <= y_next;
            if (en) begin
                a_valid_reg <= head_valid;
                m_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_px_reg   <= head_entry.base_x + 12'(x_reg);
            a_py_reg   <= head_entry.base_y + 12'(y_reg);
            a_lob_reg  <= last_texel;
            a_loi_reg  <= last_texel & head_entry.last_block;
            a_cnum_reg <= cnum_next;
            a_cop_reg  <= cop_next;
            a_anum_reg <= anum_next;
            a_aop_reg  <= aop_next;
            m_data_reg <= {apply_op(a_aop_reg, a_anum_reg),
                           apply_op(a_cop_reg[2], a_cnum_reg[2]),
                           apply_op(a_cop_reg[1], a_cnum_reg[1]),
                           apply_op(a_cop_reg[0], a_cnum_reg[0]),
                           a_py_reg, a_px_reg};
            m_last_reg <= a_lob_reg;
            m_user_reg <= a_loi_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

endmodule

// ===== rtl/bc1_bc2_bc3_block_decoder_core.sv =====
// Top level of the BC1/BC2/BC3 block decoder: configuration registers, front end, queue, back end.
//
//   channel   ports                         beat
//   --------  ----------------------------  ------------------------------------------
//   input     s_tvalid s_tready s_tdata     one compressed 4x4 block
//   output    m_tvalid m_tready m_tdata     one decoded texel
//             m_tlast m_tuser
//   config    cfg_we cfg_index cfg_wdata    one register write, taken at once
//
// A block yields one output beat per texel that lies inside the image: 16 for an
// interior block, 1 to 16 at the right and bottom edges, as the texel walk of the back
// end sets them. With the queue empty, the first texel of a block passes the queue, the
// back end's stage register and the output register before it is offered on m_tvalid.
// The queue holds QUEUE_DEPTH blocks, so input beats keep flowing while texels drain.
// Low m_tready freezes the back end; s_tready falls only when the queue is full.
// Reset empties the queue and pipeline, restarts at block (0,0) and selects BC1, 4x4.
module bc1_bc2_bc3_block_decoder_core #(
    parameter int MAX_DIM     = bcdec_pkg::MAX_DIM_DEFAULT,
    parameter int QUEUE_DEPTH = bcdec_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // alpha_word[63:0], endpoint_a[79:64], endpoint_b[95:80], color_selectors[127:96]
    input  logic [bcdec_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // pixel_x[11:0], pixel_y[23:12], red[31:24], green[39:32], blue[47:40], alpha[55:48]
    output logic [bcdec_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                             m_tlast,
    // last_of_image[0]
    output logic                             m_tuser,
    input  logic                             cfg_we,
    input  logic [bcdec_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bcdec_pkg::DIM_W-1:0]      cfg_wdata
);

    bcdec_pkg::cfg_t         cfg_reg;
    bcdec_pkg::block_entry_t push_entry, head_entry;
    logic                    push, queue_full, head_valid, pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.block_format <= bcdec_pkg::FMT_BC1;
            cfg_reg.image_width  <= bcdec_pkg::DIM_W'(4);
            cfg_reg.image_height <= bcdec_pkg::DIM_W'(4);
        end else if (cfg_we) begin
            case (cfg_index)
                bcdec_pkg::CFG_FORMAT: cfg_reg.block_format <= cfg_wdata[bcdec_pkg::FMT_W-1:0];
                bcdec_pkg::CFG_WIDTH:  cfg_reg.image_width  <= cfg_wdata;
                bcdec_pkg::CFG_HEIGHT: cfg_reg.image_height <= cfg_wdata;
                default: ;
            endcase
        end
    end

    bcdec_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .queue_full (queue_full),
        .push       (push),
        .entry      (push_entry)
    );

    bcdec_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    bcdec_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule

// ===== rtl/bcdec_checker.sv =====
// Port-level checks of the block decoder, bound to its top level.
module bcdec_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [bcdec_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic                             m_tlast,
    input logic                             m_tuser
);

    // The end of the image always closes a block.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("last_of_image beat without last_of_block");

    // A stalled output beat holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                                  && $stable(m_tuser))
        else $error("output beat changed while stalled");

    // Reset empties the texel pipeline.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    // Reset empties the block queue, so input is taken at once.
    assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("input not ready right after reset");

endmodule

bind bc1_bc2_bc3_block_decoder_core bcdec_checker u_bcdec_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
);

// ===== tb/bc1_bc2_bc3_block_decoder_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the BC1/BC2/BC3 block decoder core.
module bc1_bc2_bc3_block_decoder_core_tb;

    localparam int MAX_DIM = bcdec_pkg::MAX_DIM_DEFAULT;
    localparam int SETTLE  = 8;
    localparam int LONG_HOLD = 300;
    localparam logic [bcdec_pkg::FMT_W-1:0]     FMT_BC3   = 2'd2;
    // The fourth format code has no name of its own and decodes as BC3.
    localparam logic [bcdec_pkg::FMT_W-1:0]     FMT_ALT   = 2'd3;
    localparam logic [bcdec_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic [11:0] px;
        logic [11:0] py;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic        blk_last;
        logic        img_last;
    } texel_t;

    typedef struct packed {
        logic [bcdec_pkg::FMT_W-1:0] fmt;
        logic [bcdec_pkg::DIM_W-1:0] width;
        logic [bcdec_pkg::DIM_W-1:0] height;
        logic [63:0]                 alpha_word;
        logic [15:0]                 color0;
        logic [15:0]                 color1;
        logic [31:0]                 selectors;
        logic                        has_known;
        logic [31:0]                 known_rgba;
    } dir_row_t;

    logic                             aclk;
    logic                             aresetn   = 1'b0;
    logic                             s_tvalid  = 1'b0;
    logic                             s_tready;
    logic [bcdec_pkg::IN_DATA_W-1:0]  s_tdata   = '0;
    logic                             m_tvalid;
    logic                             m_tready  = 1'b0;
    logic [bcdec_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                             m_tlast;
    logic                             m_tuser;
    logic                             cfg_we    = 1'b0;
    logic [bcdec_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [bcdec_pkg::DIM_W-1:0]      cfg_wdata = '0;

    // Mirror of the decoder's registers and block position.
    logic [bcdec_pkg::FMT_W-1:0] fmt_reg    = bcdec_pkg::FMT_BC1;
    logic [bcdec_pkg::DIM_W-1:0] width_reg  = 13'd4;
    logic [bcdec_pkg::DIM_W-1:0] height_reg = 13'd4;
    int               blk_col    = 0;
    int               blk_row    = 0;
    int               last_count = 0;

    texel_t   texel_q[$];
    texel_t   want;
    dir_row_t dir_table[$];
    int     fail_count = 0;
    bit     full_rate  = 1'b0;
    bit     hold_req   = 1'b0;
    int     texel_wait = 0;
    int     hold_left  = 0;

    bc1_bc2_bc3_block_decoder_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("bc1_bc2_bc3_block_decoder_core_tb: FAIL");
        $finish;
    end

    function automatic int clamp_dim(input logic [bcdec_pkg::DIM_W-1:0] v);
        if (v == 0) return 1;
        if (int'(v) > MAX_DIM) return MAX_DIM;
        return int'(v);
    endfunction

    function automatic void add_row(input dir_row_t row);
        dir_table.insert(dir_table.size(), row);
    endfunction

    // Decodes one block at the current position, queues its texels and steps the position.
    function automatic void decode_block(input logic [bcdec_pkg::IN_DATA_W-1:0] blk);
        int w, h, bw, bh, t, k, ch, last_t, px, py, idx, a, a0, a1;
        int e0[3];
        int e1[3];
        int pal[4][3];
        int apal[8];
        logic [63:0] aw;
        logic [15:0] c0, c1;
        logic [31:0] sel;
        bit three_color, last_blk;
        texel_t tx;
        w  = clamp_dim(width_reg);
        h  = clamp_dim(height_reg);
        bw = (w + 3) / 4;
        bh = (h + 3) / 4;
        aw  = blk[63:0];
        c0  = blk[79:64];
        c1  = blk[95:80];
        sel = blk[127:96];
        three_color = (fmt_reg == bcdec_pkg::FMT_BC1) && (c0 <= c1);
        if (blk_col >= bw || blk_row >= bh) begin
            blk_col = 0;
            blk_row = 0;
        end
        last_blk = (blk_col == bw - 1) && (blk_row == bh - 1);

        e0[0] = int'(c0[15:11]) * 8;
        e0[1] = int'(c0[10:5]) * 4;
        e0[2] = int'(c0[4:0]) * 8;
        e1[0] = int'(c1[15:11]) * 8;
        e1[1] = int'(c1[10:5]) * 4;
        e1[2] = int'(c1[4:0]) * 8;
        for (ch = 0; ch < 3; ch++) begin
            pal[0][ch] = e0[ch];
            pal[1][ch] = e1[ch];
            if (three_color) begin
                pal[2][ch] = (e0[ch] + e1[ch]) / 2;
                pal[3][ch] = 0;
            end else begin
                pal[2][ch] = (2 * e0[ch] + e1[ch] + 1) / 3;
                pal[3][ch] = (e0[ch] + 2 * e1[ch] + 1) / 3;
            end
        end

        a0 = int'(aw[7:0]);
        a1 = int'(aw[15:8]);
        apal[0] = a0;
        apal[1] = a1;
        if (a0 > a1) begin
            for (k = 2; k < 8; k++)
                apal[k] = ((8 - k) * a0 + (k - 1) * a1 + 3) / 7;
        end else begin
            for (k = 2; k < 6; k++)
                apal[k] = ((6 - k) * a0 + (k - 1) * a1 + 2) / 5;
            apal[6] = 0;
            apal[7] = 255;
        end

        last_t = 0;
        for (t = 0; t < 16; t++) begin
            if (blk_col * 4 + t % 4 < w && blk_row * 4 + t / 4 < h) last_t = t;
        end

        last_count = 0;
        for (t = 0; t < 16; t++) begin
            px = blk_col * 4 + t % 4;
            py = blk_row * 4 + t / 4;
            if (px < w && py < h) begin
                idx = int'((sel >> (2 * t)) & 32'd3);
                case (fmt_reg)
                    bcdec_pkg::FMT_BC1: a = (three_color && idx == 3) ? 0 : 255;
                    bcdec_pkg::FMT_BC2: a = int'((aw >> (4 * t)) & 64'hF) * 17;
                    default: a = apal[int'((aw >> (16 + 3 * t)) & 64'h7)];
                endcase
                tx.px       = px[11:0];
                tx.py       = py[11:0];
                tx.red      = pal[idx][0][7:0];
                tx.green    = pal[idx][1][7:0];
                tx.blue     = pal[idx][2][7:0];
                tx.alpha    = a[7:0];
                tx.blk_last = (t == last_t);
                tx.img_last = (t == last_t) && last_blk;
                texel_q.insert(texel_q.size(), tx);
                last_count++;
            end
        end

        if (last_blk) begin
            blk_col = 0;
            blk_row = 0;
        end else if (blk_col + 1 >= bw) begin
            blk_col = 0;
            blk_row++;
        end else begin
            blk_col++;
        end
    endfunction

    function automatic void check_field(input string name, input int exp_v, input int got_v);
        if (exp_v != got_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            fail_count++;
        end
    endfunction

    task automatic send_block(input logic [bcdec_pkg::IN_DATA_W-1:0] blk);
        int gap;
        gap = full_rate ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= blk;
        do @(posedge aclk); while (!s_tready);
        decode_block(blk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (texel_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Writes all three registers on back-to-back edges, optionally poking the unused index too.
    task automatic program_regs(input logic [bcdec_pkg::DIM_W-1:0] fmt_word,
                                input logic [bcdec_pkg::DIM_W-1:0] w,
                                input logic [bcdec_pkg::DIM_W-1:0] h, input bit with_spare);
        cfg_we    <= 1'b1;
        cfg_index <= bcdec_pkg::CFG_FORMAT;
        cfg_wdata <= fmt_word;
        @(posedge aclk);
        cfg_index <= bcdec_pkg::CFG_WIDTH;
        cfg_wdata <= w;
        @(posedge aclk);
        cfg_index <= bcdec_pkg::CFG_HEIGHT;
        cfg_wdata <= h;
        @(posedge aclk);
        if (with_spare) begin
            cfg_index <= CFG_SPARE;
            cfg_wdata <= bcdec_pkg::DIM_W'($urandom);
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
        fmt_reg    = fmt_word[bcdec_pkg::FMT_W-1:0];
        width_reg  = w;
        height_reg = h;
    endtask

    // Texel receiver: checks every beat and, unless at full rate, stalls randomly after each.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            texel_wait = 0;
            hold_left  = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (texel_q.size() == 0) begin
                    $error("texel beat with nothing expected: x=%0d y=%0d",
                           m_tdata[11:0], m_tdata[23:12]);
                    fail_count++;
                end else begin
                    want = texel_q.pop_front();
                    check_field("pixel_x", want.px, m_tdata[11:0]);
                    check_field("pixel_y", want.py, m_tdata[23:12]);
                    check_field("red", want.red, m_tdata[31:24]);
                    check_field("green", want.green, m_tdata[39:32]);
                    check_field("blue", want.blue, m_tdata[47:40]);
                    check_field("alpha", want.alpha, m_tdata[55:48]);
                    check_field("last_of_block", want.blk_last, m_tlast);
                    check_field("last_of_image", want.img_last, m_tuser);
                end
                texel_wait = full_rate ? 0 : $urandom_range(0, 13);
            end
            if (hold_req) begin
                hold_left = LONG_HOLD;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (texel_wait > 0) begin
                texel_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        dir_row_t r;
        int first, ph, n;
        logic [bcdec_pkg::DIM_W-1:0] w, h;
        logic [bcdec_pkg::FMT_W-1:0] fcode;
        logic [63:0] aw;
        logic [15:0] c0, c1;
        logic [31:0] sel;

        // The first rows run at the reset setting: BC1, one 4x4 block per image.
        add_row('{bcdec_pkg::FMT_BC1, 13'd4, 13'd4, 64'h0, 16'hFFFF, 16'h0000, 32'h0,
                  1'b1, {8'd248, 8'd252, 8'd248, 8'd255}});
        add_row('{bcdec_pkg::FMT_BC1, 13'd4, 13'd4, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF,
                  16'h0000, 32'hE4E4_E4E4, 1'b0, 32'h0});
        // Punch-through black: color0 below color1 and selector three.
        add_row('{bcdec_pkg::FMT_BC1, 13'd4, 13'd4, 64'h0, 16'h0000, 16'hFFFF, 32'hFFFF_FFFF,
                  1'b1, {8'd0, 8'd0, 8'd0, 8'd0}});
        // Equal endpoints also select the three-color palette.
        add_row('{bcdec_pkg::FMT_BC1, 13'd4, 13'd4, 64'h0, 16'h1234, 16'h1234, 32'hAAAA_AAAA,
                  1'b1, {8'd16, 8'd68, 8'd160, 8'd255}});
        add_row('{bcdec_pkg::FMT_BC1, 13'd4, 13'd4, 64'h0, 16'hFFFF, 16'h0000, 32'hAAAA_AAAA,
                  1'b1, {8'd165, 8'd168, 8'd165, 8'd255}});
        add_row('{bcdec_pkg::FMT_BC1, 13'd4, 13'd4, 64'h0, 16'hFFFF, 16'h0000, 32'h5555_5555,
                  1'b1, {8'd0, 8'd0, 8'd0, 8'd255}});
        add_row('{bcdec_pkg::FMT_BC1, 13'd4, 13'd4, 64'h0, 16'h0000, 16'hFFFF, 32'hAAAA_AAAA,
                  1'b1, {8'd124, 8'd126, 8'd124, 8'd255}});
        add_row('{bcdec_pkg::FMT_BC2, 13'd4, 13'd4, 64'hFFFF_FFFF_FFFF_FFFF, 16'hF800,
                  16'h001F, 32'h0, 1'b1, {8'd248, 8'd0, 8'd0, 8'd255}});
        // BC2 keeps four colors even when color0 is below color1.
        add_row('{bcdec_pkg::FMT_BC2, 13'd4, 13'd4, 64'h0, 16'h07E0, 16'hF800, 32'hFFFF_FFFF,
                  1'b1, {8'd165, 8'd84, 8'd0, 8'd0}});
        add_row('{bcdec_pkg::FMT_BC2, 13'd4, 13'd4, 64'h0123_4567_89AB_CDEF, 16'h07E0,
                  16'h001F, 32'hE4E4_E4E4, 1'b0, 32'h0});
        add_row('{FMT_BC3, 13'd4, 13'd4, 64'h0000_0000_0000_00FF, 16'hFFFF,
                  16'hFFFF, 32'h0, 1'b1, {8'd248, 8'd252, 8'd248, 8'd255}});
        add_row('{FMT_BC3, 13'd4, 13'd4, 64'hFFFF_FFFF_FFFF_00FF, 16'h0, 16'h0,
                  32'h0, 1'b1, {8'd0, 8'd0, 8'd0, 8'd36}});
        // Four-interpolant palette: index six is zero, index seven is full.
        add_row('{FMT_BC3, 13'd4, 13'd4, 64'hDB6D_B6DB_6DB6_FF00, 16'h0, 16'h0,
                  32'h0, 1'b1, {8'd0, 8'd0, 8'd0, 8'd0}});
        add_row('{FMT_BC3, 13'd4, 13'd4, 64'hFFFF_FFFF_FFFF_FF00, 16'h0, 16'h0,
                  32'h0, 1'b1, {8'd0, 8'd0, 8'd0, 8'd255}});
        add_row('{FMT_BC3, 13'd4, 13'd4, 64'hFAC6_88D2_39E5_8080, 16'h7BEF,
                  16'h8410, 32'h1B1B_1B1B, 1'b0, 32'h0});
        add_row('{FMT_BC3, 13'd4, 13'd4, 64'h0539_77FA_C688_40C0, 16'hF81F,
                  16'h07E0, 32'hE4E4_E4E4, 1'b0, 32'h0});
        add_row('{FMT_ALT, 13'd4, 13'd4, 64'hFFFF_FFFF_FFFF_00FF, 16'h0, 16'h0,
                  32'h0, 1'b1, {8'd0, 8'd0, 8'd0, 8'd36}});
        // Clipped edge blocks, then a size change that leaves the position off the grid.
        add_row('{bcdec_pkg::FMT_BC1, 13'd5, 13'd3, 64'h0, 16'hA5F3, 16'h3C81, 32'h9E37_79B9,
                  1'b0, 32'h0});
        add_row('{bcdec_pkg::FMT_BC1, 13'd5, 13'd3, 64'h0, 16'h0841, 16'hF7BE, 32'h7F4A_7C15,
                  1'b0, 32'h0});
        add_row('{bcdec_pkg::FMT_BC2, 13'd8, 13'd8, 64'h8765_4321_0FED_CBA9, 16'hC618,
                  16'h39E7, 32'h3C3C_C3C3, 1'b0, 32'h0});
        add_row('{bcdec_pkg::FMT_BC2, 13'd8, 13'd8, 64'hF0F0_0F0F_A5A5_5A5A, 16'h001F,
                  16'hF81F, 32'h0F0F_F0F0, 1'b0, 32'h0});
        add_row('{bcdec_pkg::FMT_BC2, 13'd4, 13'd4, 64'h1111_2222_4444_8888, 16'h7BEF,
                  16'h8410, 32'hFFFF_0000, 1'b0, 32'h0});
        // Zero sizes clamp to one texel, oversize ones to the maximum.
        add_row('{bcdec_pkg::FMT_BC1, 13'd0, 13'd0, 64'h0, 16'h8000, 16'h8000, 32'hFFFF_FFFE,
                  1'b0, 32'h0});
        add_row('{FMT_BC3, 13'd8191, 13'd1, 64'hFEDC_BA98_7654_3210, 16'hFFFF,
                  16'h0001, 32'hA5A5_5A5A, 1'b0, 32'h0});
        add_row('{FMT_BC3, 13'd4096, 13'd4096, 64'h9249_2492_4924_7F80, 16'h0000,
                  16'hFFFF, 32'h1234_5678, 1'b0, 32'h0});

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_table[i]) begin
            r = dir_table[i];
            if (r.fmt != fmt_reg || r.width != width_reg || r.height != height_reg) begin
                wait_drained();
                program_regs({11'd0, r.fmt}, r.width, r.height, 1'b0);
            end
            send_block({r.selectors, r.color1, r.color0, r.alpha_word});
            if (r.has_known) begin
                first = texel_q.size() - last_count;
                texel_q[first].red   = r.known_rgba[31:24];
                texel_q[first].green = r.known_rgba[23:16];
                texel_q[first].blue  = r.known_rgba[15:8];
                texel_q[first].alpha = r.known_rgba[7:0];
            end
        end

        for (ph = 0; ph < 6; ph++) begin
            wait_drained();
            full_rate = (ph == 2) || (ph == 4);
            fcode = (ph < 4) ? bcdec_pkg::FMT_W'(ph) : bcdec_pkg::FMT_W'($urandom_range(0, 3));
            w = bcdec_pkg::DIM_W'($urandom_range(1, 13));
            h = bcdec_pkg::DIM_W'($urandom_range(1, 13));
            if (ph == 3) begin
                w = 13'd4096;
                h = bcdec_pkg::DIM_W'($urandom_range(1, 6));
            end
            program_regs({11'($urandom), fcode}, w, h, ph == 0);
            // The receiver holds off while the sender keeps offering beats at full rate.
            if (ph == 2) hold_req = 1'b1;
            for (n = 0; n < 16; n++) begin
                aw  = {$urandom, $urandom};
                c0  = 16'($urandom);
                c1  = 16'($urandom);
                sel = $urandom;
                case ($urandom_range(0, 5))
                    0: c1 = c0;
                    1: aw[15:8] = aw[7:0];
                    default: ;
                endcase
                send_block({sel, c1, c0, aw});
            end
        end

        wait_drained();
        if (fail_count == 0) begin
            $display("bc1_bc2_bc3_block_decoder_core_tb: PASS");
        end else begin
            $display("bc1_bc2_bc3_block_decoder_core_tb: FAIL");
        end
        $finish;
    end

endmodule

// ===== bc1_bc2_bc3_block_decoder_core.f =====
rtl/bcdec_pkg.sv
rtl/bcdec_front.sv
rtl/bcdec_queue.sv
rtl/bcdec_back.sv
rtl/bc1_bc2_bc3_block_decoder_core.sv
rtl/bcdec_checker.sv
tb/bc1_bc2_bc3_block_decoder_core_tb.sv
